FILE: rtl/sbwp_pkg.sv
package sbwp_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MULT,
    ST_DONE
  } sbwp_state_e;

  // configuration register indexes
  localparam logic [2:0] REG_QUAT      = 3'd0;
  localparam logic [2:0] REG_OFFSET_X  = 3'd1;
  localparam logic [2:0] REG_OFFSET_Y  = 3'd2;
  localparam logic [2:0] REG_OFFSET_Z  = 3'd3;
  localparam logic [2:0] REG_ANG_START = 3'd4;
  localparam logic [2:0] REG_ANG_STEP  = 3'd5;

  // multiplier schedule, one issue per cycle
  localparam logic [4:0] MS_QXX   = 5'd0;
  localparam logic [4:0] MS_QYY   = 5'd1;
  localparam logic [4:0] MS_QZZ   = 5'd2;
  localparam logic [4:0] MS_QXY   = 5'd3;
  localparam logic [4:0] MS_QZW   = 5'd4;
  localparam logic [4:0] MS_QXZ   = 5'd5;
  localparam logic [4:0] MS_QYW   = 5'd6;
  localparam logic [4:0] MS_QYZ   = 5'd7;
  localparam logic [4:0] MS_QXW   = 5'd8;
  localparam logic [4:0] MS_GX    = 5'd9;
  localparam logic [4:0] MS_GY    = 5'd10;
  localparam logic [4:0] MS_R00   = 5'd11;
  localparam logic [4:0] MS_R01   = 5'd12;
  localparam logic [4:0] MS_R10   = 5'd13;
  localparam logic [4:0] MS_R11   = 5'd14;
  localparam logic [4:0] MS_R20   = 5'd15;
  localparam logic [4:0] MS_R21   = 5'd16;
  localparam logic [4:0] MS_LAST  = 5'd17;

  localparam logic [15:0] NO_RETURN = 16'hFFFF;
  localparam int AngPi     = 25736;
  localparam int AngHalfPi = 12868;
  localparam int AngTwoPi  = 51472;
  localparam int TabLen    = 24;

  localparam logic signed [35:0] GAIN_Q30   = 36'sd652032874;
  localparam logic signed [71:0] ROUND_GAIN = 72'sd1 <<< 41;
  localparam logic signed [71:0] ROUND_MAT  = 72'sd1 <<< 31;
  localparam logic signed [34:0] ONE_Q28    = 35'sd1 <<< 28;

  localparam int MW = 36;  // multiplier operand width
  localparam int PW = 24;  // local point width, Q4 mm

  function automatic logic signed [32:0] atan_q30(input logic [4:0] idx);
    logic signed [32:0] v;
    unique case (idx)
      5'd0:  v = 33'sd843314857;
      5'd1:  v = 33'sd497837829;
      5'd2:  v = 33'sd263043837;
      5'd3:  v = 33'sd133525159;
      5'd4:  v = 33'sd67021687;
      5'd5:  v = 33'sd33543516;
      5'd6:  v = 33'sd16775851;
      5'd7:  v = 33'sd8388437;
      5'd8:  v = 33'sd4194283;
      5'd9:  v = 33'sd2097149;
      5'd10: v = 33'sd1048576;
      5'd11: v = 33'sd524288;
      5'd12: v = 33'sd262144;
      5'd13: v = 33'sd131072;
      5'd14: v = 33'sd65536;
      5'd15: v = 33'sd32768;
      5'd16: v = 33'sd16384;
      5'd17: v = 33'sd8192;
      5'd18: v = 33'sd4096;
      5'd19: v = 33'sd2048;
      5'd20: v = 33'sd1024;
      5'd21: v = 33'sd512;
      5'd22: v = 33'sd256;
      5'd23: v = 33'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > 41'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -41'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/sbwp_if.sv
interface sbwp_beam_if;
  logic        valid;
  logic        ready;
  logic [15:0] beam_range;
  logic        first_beam;
  modport source (output valid, output beam_range, output first_beam, input ready);
  modport sink (input valid, input beam_range, input first_beam, output ready);
endinterface

interface sbwp_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               point_valid;
  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output point_valid, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input point_valid, output ready);
endinterface

FILE: rtl/sbwp_mul.sv
module sbwp_mul import sbwp_pkg::*; (
  input  logic                   clk_i,
  input  logic signed [MW-1:0]   a_i,
  input  logic signed [MW-1:0]   b_i,
  output logic signed [2*MW-1:0] p_o
);

  logic signed [2*MW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: rtl/scan_beam_to_world_point.sv
// scan_beam_to_world_point: one beam range in, one world point out. The beam
// angle is reloaded from angle_start on a first beam and otherwise advanced by
// angle_step, then wrapped into [-pi, pi]. A CORDIC of min(CORDIC_STEPS, 24)
// iterations forms the local point, and one shared registered multiplier then
// runs 17 products (quaternion terms, gain correction, rotation rows) and a
// final drain step. An item with a return passes through the CORDIC and
// multiplier states before its result is loaded; a no-return beam goes straight
// to the done state. The input is ready again in the cycle after the result
// is loaded into the output register, and it is not ready while an item is in
// work; a finished result sits in the output register so the next beam can be
// taken before it is drained.
module scan_beam_to_world_point import sbwp_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  sbwp_beam_if.sink    beam_i,
  sbwp_point_if.source point_o
);

  localparam int NSTEPS = (CORDIC_STEPS > TabLen) ? TabLen : CORDIC_STEPS;
  localparam int IW     = $clog2(NSTEPS + 1);

  // configuration
  logic [63:0]        quat_q;
  logic signed [31:0] off_x_q, off_y_q, off_z_q;
  logic signed [15:0] ang_start_q, ang_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q      <= 64'h4000_0000_0000_0000;
      off_x_q     <= '0;
      off_y_q     <= '0;
      off_z_q     <= '0;
      ang_start_q <= '0;
      ang_step_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_QUAT:      quat_q      <= cfg_data_i;
        REG_OFFSET_X:  off_x_q     <= cfg_data_i[31:0];
        REG_OFFSET_Y:  off_y_q     <= cfg_data_i[31:0];
        REG_OFFSET_Z:  off_z_q     <= cfg_data_i[31:0];
        REG_ANG_START: ang_start_q <= cfg_data_i[15:0];
        REG_ANG_STEP:  ang_step_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  sbwp_state_e state_q, state_d;
  logic [IW-1:0] iter_q;
  logic [4:0]    mstep_q;
  logic          in_xfer, out_xfer, load_out, no_ret;

  assign in_xfer  = beam_i.valid && beam_i.ready;
  assign out_xfer = point_o.valid && point_o.ready;
  assign no_ret   = (beam_i.beam_range == NO_RETURN);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (beam_i.valid) state_d = no_ret ? ST_DONE : ST_CORDIC;
      ST_CORDIC: if (iter_q == IW'(NSTEPS - 1)) state_d = ST_MULT;
      ST_MULT:   if (mstep_q == MS_LAST) state_d = ST_DONE;
      ST_DONE:   if (load_out) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    beam_i.ready = (state_q == ST_IDLE);
    load_out     = (state_q == ST_DONE) && (!point_o.valid || point_o.ready);
  end

  // beam angle update and wrap
  logic signed [15:0] angle_q;
  logic signed [16:0] ang_raw, ang_wrap;

  always_comb begin
    ang_raw = beam_i.first_beam ? 17'(ang_start_q) : (17'(angle_q) + 17'(ang_step_q));
    if (ang_raw > 17'(AngPi)) begin
      ang_wrap = ang_raw - 17'(AngTwoPi);
    end else if (ang_raw < -17'(AngPi)) begin
      ang_wrap = ang_raw + 17'(AngTwoPi);
    end else begin
      ang_wrap = ang_raw;
    end
  end

  // fold to [-pi/2, pi/2] before the cordic
  logic signed [16:0] ang_fold;
  logic               flip_new;
  always_comb begin
    flip_new = 1'b0;
    ang_fold = ang_wrap;
    if (ang_wrap > 17'(AngHalfPi)) begin
      ang_fold = ang_wrap - 17'(AngPi);
      flip_new = 1'b1;
    end else if (ang_wrap < -17'(AngHalfPi)) begin
      ang_fold = ang_wrap + 17'(AngPi);
      flip_new = 1'b1;
    end
  end

  // datapath
  logic signed [MW-1:0] x_q, y_q;
  logic signed [32:0]   z_q;
  logic                 flip_q;
  logic signed [PW-1:0] px_q, py_q;
  logic signed [31:0]   prod_q [9];
  logic signed [71:0]   acc_q;
  logic signed [31:0]   res_x_q, res_y_q, res_z_q;
  logic                 res_v_q;

  logic signed [MW-1:0] x_sh, y_sh;
  assign x_sh = x_q >>> iter_q;
  assign y_sh = y_q >>> iter_q;

  // rotation matrix from stored quaternion products, q28
  logic signed [15:0] qx, qy, qz, qw;
  logic signed [34:0] r00, r01, r10, r11, r20, r21;
  assign qx = quat_q[15:0];
  assign qy = quat_q[31:16];
  assign qz = quat_q[47:32];
  assign qw = quat_q[63:48];

  always_comb begin
    r00 = ONE_Q28 - ((35'(prod_q[1]) + 35'(prod_q[2])) <<< 1);
    r11 = ONE_Q28 - ((35'(prod_q[0]) + 35'(prod_q[2])) <<< 1);
    r01 = (35'(prod_q[3]) - 35'(prod_q[4])) <<< 1;
    r10 = (35'(prod_q[3]) + 35'(prod_q[4])) <<< 1;
    r20 = (35'(prod_q[5]) - 35'(prod_q[6])) <<< 1;
    r21 = (35'(prod_q[7]) + 35'(prod_q[8])) <<< 1;
  end

  // operand select for the shared multiplier
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (mstep_q)
      MS_QXX: begin mul_a = MW'(qx); mul_b = MW'(qx); end
      MS_QYY: begin mul_a = MW'(qy); mul_b = MW'(qy); end
      MS_QZZ: begin mul_a = MW'(qz); mul_b = MW'(qz); end
      MS_QXY: begin mul_a = MW'(qx); mul_b = MW'(qy); end
      MS_QZW: begin mul_a = MW'(qz); mul_b = MW'(qw); end
      MS_QXZ: begin mul_a = MW'(qx); mul_b = MW'(qz); end
      MS_QYW: begin mul_a = MW'(qy); mul_b = MW'(qw); end
      MS_QYZ: begin mul_a = MW'(qy); mul_b = MW'(qz); end
      MS_QXW: begin mul_a = MW'(qx); mul_b = MW'(qw); end
      MS_GX:  begin mul_a = x_q; mul_b = GAIN_Q30; end
      MS_GY:  begin mul_a = y_q; mul_b = GAIN_Q30; end
      MS_R00: begin mul_a = MW'(r00); mul_b = MW'(px_q); end
      MS_R01: begin mul_a = MW'(r01); mul_b = MW'(py_q); end
      MS_R10: begin mul_a = MW'(r10); mul_b = MW'(px_q); end
      MS_R11: begin mul_a = MW'(r11); mul_b = MW'(py_q); end
      MS_R20: begin mul_a = MW'(r20); mul_b = MW'(px_q); end
      MS_R21: begin mul_a = MW'(r21); mul_b = MW'(py_q); end
      default: ;
    endcase
  end

  sbwp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // consumer side of the multiplier, reading each product in the cycle after its issue
  logic [4:0]           cstep;
  logic signed [71:0]   gain_sum, acc_sum;
  logic signed [PW-1:0] gain_val;
  logic signed [40:0]   row_val;
  assign cstep    = mstep_q - 5'd1;
  assign gain_sum = (mul_p + ROUND_GAIN) >>> 42;
  assign gain_val = flip_q ? -gain_sum[PW-1:0] : gain_sum[PW-1:0];
  assign acc_sum  = (acc_q + mul_p) >>> 32;

  // row sum keeps its sign before the offset is added
  always_comb begin
    unique case (cstep)
      MS_R01:  row_val = 41'(acc_sum) + 41'(off_x_q);
      MS_R11:  row_val = 41'(acc_sum) + 41'(off_y_q);
      default: row_val = 41'(acc_sum) + 41'(off_z_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && !no_ret) begin
      x_q    <= MW'({beam_i.beam_range, 16'h0000});
      y_q    <= '0;
      z_q    <= 33'(ang_fold) <<< 17;
      flip_q <= flip_new;
    end else if (state_q == ST_CORDIC) begin
      if (!z_q[32]) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_q30(5'(iter_q));
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_q30(5'(iter_q));
      end
    end
    if (in_xfer && no_ret) begin
      res_x_q <= '0;
      res_y_q <= '0;
      res_z_q <= '0;
      res_v_q <= 1'b0;
    end else if (state_q == ST_MULT && mstep_q != 5'd0) begin
      res_v_q <= 1'b1;
      priority if (cstep <= MS_QXW) begin
        prod_q[4'(cstep)] <= mul_p[31:0];
      end else if (cstep == MS_GX) begin
        px_q <= gain_val;
      end else if (cstep == MS_GY) begin
        py_q <= gain_val;
      end else if (cstep == MS_R00 || cstep == MS_R10 || cstep == MS_R20) begin
        acc_q <= ROUND_MAT + mul_p;
      end else if (cstep == MS_R01) begin
        res_x_q <= sat32(row_val);
      end else if (cstep == MS_R11) begin
        res_y_q <= sat32(row_val);
      end else begin
        res_z_q <= sat32(row_val);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
      mstep_q <= '0;
      angle_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        angle_q <= ang_wrap[15:0];
      end
      if (state_q == ST_CORDIC) begin
        iter_q <= iter_q + IW'(1);
      end else begin
        iter_q <= '0;
      end
      if (state_q == ST_MULT) begin
        mstep_q <= mstep_q + 5'd1;
      end else begin
        mstep_q <= '0;
      end
    end
  end

  // output register
  logic               out_v_q;
  logic signed [31:0] out_x_q, out_y_q, out_z_q;
  logic               out_pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q <= 1'b1;
    end else if (out_xfer) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_x_q  <= res_x_q;
      out_y_q  <= res_y_q;
      out_z_q  <= res_z_q;
      out_pv_q <= res_v_q;
    end
  end

  assign point_o.valid       = out_v_q;
  assign point_o.pos_x       = out_x_q;
  assign point_o.pos_y       = out_y_q;
  assign point_o.pos_z       = out_z_q;
  assign point_o.point_valid = out_pv_q;

endmodule

FILE: rtl/sbwp_chk.sv
module sbwp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] pos_x_i,
  input logic [31:0] pos_y_i,
  input logic [31:0] pos_z_i,
  input logic        point_valid_i
);

  // one item in work at a time
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transfer");

  // no-return point carries zero coordinates
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !point_valid_i |->
      pos_x_i == 32'd0 && pos_y_i == 32'd0 && pos_z_i == 32'd0)
    else $error("invalid point with nonzero coordinates");

  // a result cannot appear without a prior input transfer
  a_no_result_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |->
      !in_ready_i || $past(in_valid_i && in_ready_i) || $past(!in_ready_i))
    else $error("result without an input transfer");

  // stalled result holds: valid, x coordinate and point-valid flag stay stable
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(pos_x_i) && $stable(point_valid_i))
    else $error("stalled result changed");

endmodule

bind scan_beam_to_world_point sbwp_chk u_sbwp_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (beam_i.valid),
  .in_ready_i    (beam_i.ready),
  .out_valid_i   (point_o.valid),
  .out_ready_i   (point_o.ready),
  .pos_x_i       (point_o.pos_x),
  .pos_y_i       (point_o.pos_y),
  .pos_z_i       (point_o.pos_z),
  .point_valid_i (point_o.point_valid)
);
